// File: rtl/refcounted_key_registration_table_unit_macros.svh
// Assertion macros for the key registration table.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef REFCOUNTED_KEY_REGISTRATION_TABLE_UNIT_MACROS_SVH
`define REFCOUNTED_KEY_REGISTRATION_TABLE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold on every clock edge outside reset.
`define RKRT_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("rkrt: assertion failed");
// Condition must never be true on a clock edge outside reset.
`define RKRT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("rkrt: forbidden condition seen");
`else
`define RKRT_ASSERT(label, clk, rst_n, prop)
`define RKRT_NEVER(label, clk, rst_n, cond)
`endif
`endif

// File: rtl/rkrt_pkg.sv
// Package for the key registration table: sizes, command and status codes, entry record.
// No dependencies; imported by refcounted_key_registration_table_unit.
package rkrt_pkg;

    // Table geometry.
    localparam int TableSlots = 32;
    localparam int SlotW      = $clog2(TableSlots);
    localparam int MaxResults = 32;

    // Field widths of the transfer payloads.
    localparam int CmdW        = 2;
    localparam int KeyW        = 64;
    localparam int FlagsW      = 8;
    localparam int CountW      = 6;
    localparam int StatusW     = 2;
    localparam int SlotFieldW  = 5;
    localparam int RefsW       = 16;

    // Context flag bit that enables aggregation.
    localparam int AggFlagBit = 4;

    typedef enum logic [CmdW-1:0] {
        CMD_REGISTER  = 2'd0,
        CMD_REVOKE    = 2'd1,
        CMD_CREATE    = 2'd2,
        CMD_ENUMERATE = 2'd3
    } cmd_t;

    typedef enum logic [StatusW-1:0] {
        STATUS_OK      = 2'd0,
        STATUS_NOTREG  = 2'd1,
        STATUS_MISSING = 2'd2,
        STATUS_NOIFACE = 2'd3
    } status_t;

    // One table entry as held in the entry memory.
    typedef struct packed {
        logic [KeyW-1:0]   key_hi;
        logic [KeyW-1:0]   key_lo;
        logic [FlagsW-1:0] flags;
        logic [RefsW-1:0]  refs;
    } entry_t;

endpackage

// File: rtl/refcounted_key_registration_table_unit.sv
// Register: the result is registered in the cycle after the transfer. Revoke and create: the
// result follows the slot-by-slot lookup through the entry memory (one registered read a cycle).
// Enumerate: the first entry follows the same slot-by-slot walk, then one slot per
// cycle while the output is taken; one command at a time.
// Reset (aresetn low, synchronous) clears all valid bits and the control state; the entry
// memory is not cleared, an entry whose valid bit is low is never used.
`include "refcounted_key_registration_table_unit_macros.svh"

module refcounted_key_registration_table_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    // Command channel.
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [rkrt_pkg::CmdW-1:0]         s_cmd,
    input  logic [rkrt_pkg::KeyW-1:0]         s_key_hi,
    input  logic [rkrt_pkg::KeyW-1:0]         s_key_lo,
    input  logic [rkrt_pkg::FlagsW-1:0]       s_context_flags,
    input  logic                              s_outer_present,
    input  logic                              s_factory_ok,
    input  logic [rkrt_pkg::CountW-1:0]       s_max_count,
    // Result channel.
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [rkrt_pkg::StatusW-1:0]      m_status,
    output logic [rkrt_pkg::SlotFieldW-1:0]   m_slot,
    output logic [rkrt_pkg::RefsW-1:0]        m_ref_count,
    output logic                              m_aggregate_selected,
    output logic [rkrt_pkg::KeyW-1:0]         m_entry_key_hi,
    output logic [rkrt_pkg::KeyW-1:0]         m_entry_key_lo,
    output logic [rkrt_pkg::CountW-1:0]       m_item_count,
    output logic                              m_entry_present,
    output logic                              m_last
);
    import rkrt_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_ENUM = 3'b100
    } state_t;

    localparam logic [SlotW-1:0] LastSlot = SlotW'(TableSlots - 1);

    // Control state.
    state_t                 state_reg, state_next;
    logic [TableSlots-1:0]  valid_reg, valid_next;
    logic [SlotW-1:0]       pend_idx_reg, pend_idx_next;
    logic [CountW-1:0]      n_reg, n_next;
    logic [CountW-1:0]      limit_reg, limit_next;

    // Command fields held for the lookup.
    cmd_t                   cmd_reg, cmd_next;
    logic [KeyW-1:0]        key_hi_reg, key_hi_next;
    logic [KeyW-1:0]        key_lo_reg, key_lo_next;
    logic                   outer_reg, outer_next;
    logic                   fok_reg, fok_next;

    // Entry memory and its ports.
    entry_t                 mem [TableSlots];
    entry_t                 rdata_reg;
    logic                   rd_en;
    logic [SlotW-1:0]       rd_addr;
    logic                   mem_we;
    logic [SlotW-1:0]       mem_waddr;
    entry_t                 mem_wdata;

    // Output register.
    logic                   m_valid_reg;
    status_t                m_status_reg, o_status;
    logic [SlotFieldW-1:0]  m_slot_reg, o_slot;
    logic [RefsW-1:0]       m_ref_count_reg, o_ref_count;
    logic                   m_agg_reg, o_agg;
    logic [KeyW-1:0]        m_key_hi_reg, o_key_hi;
    logic [KeyW-1:0]        m_key_lo_reg, o_key_lo;
    logic [CountW-1:0]      m_item_count_reg, o_item_count;
    logic                   m_present_reg, o_present;
    logic                   m_last_reg, o_last;
    logic                   out_load;

    // Helpers.
    logic                   s_fire;
    logic                   out_free;
    logic                   table_full;
    logic [SlotW-1:0]       free_idx;
    logic                   hit;
    logic                   emit;
    logic                   rest_valid;
    logic [TableSlots-1:0]  valid_above;
    logic [RefsW-1:0]       new_refs;
    logic [CountW-1:0]      n_plus;
    logic                   enum_last;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE) && out_free;
    assign s_fire   = s_valid && s_ready;

    // Lowest free slot for a registration.
    assign table_full = &valid_reg;
    always_comb begin
        free_idx = '0;
        for (int i = TableSlots - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_idx = SlotW'(i);
            end
        end
    end

    // Lookup compare on the entry read in the previous cycle.
    assign hit = valid_reg[pend_idx_reg] && (rdata_reg.key_hi == key_hi_reg)
                 && (rdata_reg.key_lo == key_lo_reg);

    // Enumeration: is there any valid slot beyond the current one.
    assign emit        = valid_reg[pend_idx_reg];
    assign valid_above = valid_reg >> pend_idx_reg;
    assign rest_valid  = |valid_above[TableSlots-1:1];
    assign n_plus      = n_reg + CountW'(1);
    assign enum_last   = (n_plus == limit_reg) || !rest_valid;

    // Main sequencer: decides memory accesses, table updates and the next result.
    always_comb begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        pend_idx_next = pend_idx_reg;
        n_next        = n_reg;
        limit_next    = limit_reg;
        cmd_next      = cmd_reg;
        key_hi_next   = key_hi_reg;
        key_lo_next   = key_lo_reg;
        outer_next    = outer_reg;
        fok_next      = fok_reg;
        rd_en         = 1'b0;
        rd_addr       = pend_idx_reg;
        mem_we        = 1'b0;
        mem_waddr     = pend_idx_reg;
        mem_wdata     = rdata_reg;
        new_refs      = rdata_reg.refs;
        out_load      = 1'b0;
        o_status      = STATUS_OK;
        o_slot        = '0;
        o_ref_count   = '0;
        o_agg         = 1'b0;
        o_key_hi      = '0;
        o_key_lo      = '0;
        o_item_count  = '0;
        o_present     = 1'b0;
        o_last        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    cmd_next    = cmd_t'(s_cmd);
                    key_hi_next = s_key_hi;
                    key_lo_next = s_key_lo;
                    outer_next  = s_outer_present;
                    fok_next    = s_factory_ok;
                    case (cmd_t'(s_cmd))
                        CMD_REGISTER: begin
                            out_load = 1'b1;
                            o_last   = 1'b1;
                            if (table_full) begin
                                o_status = STATUS_NOTREG;
                            end else begin
                                mem_we           = 1'b1;
                                mem_waddr        = free_idx;
                                mem_wdata.key_hi = s_key_hi;
                                mem_wdata.key_lo = s_key_lo;
                                mem_wdata.flags  = s_context_flags;
                                mem_wdata.refs   = RefsW'(1);
                                valid_next[free_idx] = 1'b1;
                                o_slot      = SlotFieldW'(free_idx);
                                o_ref_count = RefsW'(1);
                            end
                        end
                        CMD_REVOKE, CMD_CREATE: begin
                            rd_en         = 1'b1;
                            rd_addr       = '0;
                            pend_idx_next = '0;
                            state_next    = ST_SCAN;
                        end
                        CMD_ENUMERATE: begin
                            if ((valid_reg == '0) || (s_max_count == '0)) begin
                                out_load = 1'b1;
                                o_last   = 1'b1;
                            end else begin
                                rd_en         = 1'b1;
                                rd_addr       = '0;
                                pend_idx_next = '0;
                                n_next        = '0;
                                limit_next    = (s_max_count > CountW'(MaxResults)) ?
                                                CountW'(MaxResults) : s_max_count;
                                state_next    = ST_ENUM;
                            end
                        end
                        default: begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            // Key lookup for revoke and create, one slot per cycle.
            ST_SCAN: begin
                if (hit) begin
                    out_load   = 1'b1;
                    o_last     = 1'b1;
                    o_slot     = SlotFieldW'(pend_idx_reg);
                    state_next = ST_IDLE;
                    if (cmd_reg == CMD_REVOKE) begin
                        new_refs       = (rdata_reg.refs == '0) ? '0 :
                                         rdata_reg.refs - RefsW'(1);
                        mem_we         = 1'b1;
                        mem_wdata.refs = new_refs;
                        valid_next[pend_idx_reg] = (new_refs != '0);
                        o_ref_count    = new_refs;
                    end else if (!fok_reg) begin
                        o_status    = STATUS_NOIFACE;
                        o_ref_count = rdata_reg.refs;
                    end else begin
                        new_refs       = (rdata_reg.refs == '1) ? rdata_reg.refs :
                                         rdata_reg.refs + RefsW'(1);
                        mem_we         = 1'b1;
                        mem_wdata.refs = new_refs;
                        o_ref_count    = new_refs;
                        o_agg          = outer_reg && rdata_reg.flags[AggFlagBit];
                    end
                end else if (pend_idx_reg == LastSlot) begin
                    out_load   = 1'b1;
                    o_last     = 1'b1;
                    o_status   = (cmd_reg == CMD_REVOKE) ? STATUS_NOTREG : STATUS_MISSING;
                    state_next = ST_IDLE;
                end else begin
                    rd_en         = 1'b1;
                    rd_addr       = pend_idx_reg + SlotW'(1);
                    pend_idx_next = pend_idx_reg + SlotW'(1);
                end
            end

            // Enumeration: report valid slots in order, holding while the output is busy.
            ST_ENUM: begin
                if (emit && !out_free) begin
                    state_next = ST_ENUM;
                end else begin
                    if (emit) begin
                        out_load     = 1'b1;
                        o_slot       = SlotFieldW'(pend_idx_reg);
                        o_ref_count  = rdata_reg.refs;
                        o_key_hi     = rdata_reg.key_hi;
                        o_key_lo     = rdata_reg.key_lo;
                        o_item_count = n_plus;
                        o_present    = 1'b1;
                        o_last       = enum_last;
                        n_next       = n_plus;
                    end
                    if ((emit && enum_last) || (pend_idx_reg == LastSlot)) begin
                        state_next = ST_IDLE;
                    end else begin
                        rd_en         = 1'b1;
                        rd_addr       = pend_idx_reg + SlotW'(1);
                        pend_idx_next = pend_idx_reg + SlotW'(1);
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Entry memory: one write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_en) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            valid_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers for the command and the result.
    always_ff @(posedge aclk) begin
        pend_idx_reg <= pend_idx_next;
        n_reg        <= n_next;
        limit_reg    <= limit_next;
        cmd_reg      <= cmd_next;
        key_hi_reg   <= key_hi_next;
        key_lo_reg   <= key_lo_next;
        outer_reg    <= outer_next;
        fok_reg      <= fok_next;
        if (out_load) begin
            m_status_reg     <= o_status;
            m_slot_reg       <= o_slot;
            m_ref_count_reg  <= o_ref_count;
            m_agg_reg        <= o_agg;
            m_key_hi_reg     <= o_key_hi;
            m_key_lo_reg     <= o_key_lo;
            m_item_count_reg <= o_item_count;
            m_present_reg    <= o_present;
            m_last_reg       <= o_last;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_status             = m_status_reg;
    assign m_slot               = m_slot_reg;
    assign m_ref_count          = m_ref_count_reg;
    assign m_aggregate_selected = m_agg_reg;
    assign m_entry_key_hi       = m_key_hi_reg;
    assign m_entry_key_lo       = m_key_lo_reg;
    assign m_item_count         = m_item_count_reg;
    assign m_entry_present      = m_present_reg;
    assign m_last               = m_last_reg;

    // A lookup runs only after the previous result has left the output register.
    `RKRT_NEVER(a_scan_output_idle, aclk, aresetn, (state_reg == ST_SCAN) && m_valid_reg)
    // An enumeration never passes its entry limit.
    `RKRT_ASSERT(a_enum_limit, aclk, aresetn, (state_reg == ST_ENUM) |-> (n_reg < limit_reg))
    // Registration into a full table answers with the not-registered status.
    `RKRT_ASSERT(a_full_register, aclk, aresetn,
                 (s_fire && (s_cmd == CMD_REGISTER) && table_full)
                 |=> (m_valid_reg && (m_status_reg == STATUS_NOTREG)))
    // At most one slot becomes valid per cycle.
    `RKRT_ASSERT(a_one_claim, aclk, aresetn,
                 $countones(valid_reg) <= $countones($past(valid_reg)) + 1)

endmodule

// File: tb/tb_refcounted_key_registration_table_unit.sv
// Self-checking testbench for the reference-counted key registration table.
// Uses rkrt_pkg for codes and widths; drives refcounted_key_registration_table_unit
// and checks every result transfer against its own model of the table.
`timescale 1ns / 100ps

module tb_refcounted_key_registration_table_unit;
    import rkrt_pkg::*;

    localparam int SettleCycles = 2 * TableSlots + 8;

    // One expected or observed result transfer.
    typedef struct packed {
        status_t           status;
        logic [SlotFieldW-1:0] slot;
        logic [RefsW-1:0]  refs;
        logic              agg;
        logic [KeyW-1:0]   khi;
        logic [KeyW-1:0]   klo;
        logic [CountW-1:0] cnt;
        logic              present;
        logic              last;
    } table_result_t;

    // One command, with an optional hand-written result for single-result rows.
    typedef struct packed {
        cmd_t              cmd;
        logic [KeyW-1:0]   khi;
        logic [KeyW-1:0]   klo;
        logic [FlagsW-1:0] flags;
        logic              outer;
        logic              fok;
        logic [CountW-1:0] maxc;
        logic              typed;
        status_t           t_status;
        logic [SlotFieldW-1:0] t_slot;
        logic [RefsW-1:0]  t_refs;
    } command_row_t;

    logic aclk;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [CmdW-1:0]   s_cmd = '0;
    logic [KeyW-1:0]   s_key_hi = '0;
    logic [KeyW-1:0]   s_key_lo = '0;
    logic [FlagsW-1:0] s_context_flags = '0;
    logic s_outer_present = 1'b0;
    logic s_factory_ok = 1'b0;
    logic [CountW-1:0] s_max_count = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [StatusW-1:0]    m_status;
    logic [SlotFieldW-1:0] m_slot;
    logic [RefsW-1:0]      m_ref_count;
    logic                  m_aggregate_selected;
    logic [KeyW-1:0]       m_entry_key_hi;
    logic [KeyW-1:0]       m_entry_key_lo;
    logic [CountW-1:0]     m_item_count;
    logic                  m_entry_present;
    logic                  m_last;

    refcounted_key_registration_table_unit dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_cmd                (s_cmd),
        .s_key_hi             (s_key_hi),
        .s_key_lo             (s_key_lo),
        .s_context_flags      (s_context_flags),
        .s_outer_present      (s_outer_present),
        .s_factory_ok         (s_factory_ok),
        .s_max_count          (s_max_count),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_status             (m_status),
        .m_slot               (m_slot),
        .m_ref_count          (m_ref_count),
        .m_aggregate_selected (m_aggregate_selected),
        .m_entry_key_hi       (m_entry_key_hi),
        .m_entry_key_lo       (m_entry_key_lo),
        .m_item_count         (m_item_count),
        .m_entry_present      (m_entry_present),
        .m_last               (m_last)
    );

    // Shadow copy of the table, updated as each command transfer is taken.
    logic              tbl_valid [TableSlots];
    logic [KeyW-1:0]   tbl_key_hi [TableSlots];
    logic [KeyW-1:0]   tbl_key_lo [TableSlots];
    logic [FlagsW-1:0] tbl_flags [TableSlots];
    logic [RefsW-1:0]  tbl_refs [TableSlots];

    table_result_t awaited_results[$];
    command_row_t  directed_rows[$];
    logic [KeyW-1:0] pool_hi [6];
    logic [KeyW-1:0] pool_lo [6];
    bit idle_enabled = 1'b1;
    int error_count = 0;
    int commands_sent = 0;
    int results_checked = 0;

    // Clock with a 4 ns period.
    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    // Hard limit on the run, far beyond the longest run with slow lookups and stalls.
    initial begin
        #1_000_000;
        $display("tb_refcounted_key_registration_table_unit: errors");
        $finish;
    end

    // Result side backpressure: random stalls unless idling is switched off.
    always @(posedge aclk) begin
        m_ready <= !idle_enabled || ($urandom_range(0, 99) >= 34);
    end

    function automatic void clear_table_slot(int i);
        tbl_valid[i] = 1'b0;
        tbl_key_hi[i] = '0;
        tbl_key_lo[i] = '0;
        tbl_flags[i] = '0;
        tbl_refs[i] = '0;
    endfunction

    // Applies one command to the shadow table and queues the results it causes.
    function automatic void apply_table_command(command_row_t c);
        table_result_t r;
        int hit;
        int free_slot;
        int limit;
        int n;
        r = '0;
        r.last = 1'b1;
        hit = -1;
        free_slot = -1;
        for (int i = 0; i < TableSlots; i++) begin
            if (hit < 0 && tbl_valid[i] && tbl_key_hi[i] == c.khi && tbl_key_lo[i] == c.klo)
                hit = i;
            if (free_slot < 0 && !tbl_valid[i])
                free_slot = i;
        end
        case (c.cmd)
            CMD_REGISTER: begin
                if (free_slot < 0) begin
                    r.status = STATUS_NOTREG;
                end else begin
                    tbl_valid[free_slot] = 1'b1;
                    tbl_key_hi[free_slot] = c.khi;
                    tbl_key_lo[free_slot] = c.klo;
                    tbl_flags[free_slot] = c.flags;
                    tbl_refs[free_slot] = 1;
                    r.slot = free_slot[SlotFieldW-1:0];
                    r.refs = 1;
                end
                awaited_results.push_back(r);
            end
            CMD_REVOKE: begin
                if (hit < 0) begin
                    r.status = STATUS_NOTREG;
                end else begin
                    if (tbl_refs[hit] != 0)
                        tbl_refs[hit] = tbl_refs[hit] - 1'b1;
                    r.slot = hit[SlotFieldW-1:0];
                    r.refs = tbl_refs[hit];
                    if (tbl_refs[hit] == 0)
                        clear_table_slot(hit);
                end
                awaited_results.push_back(r);
            end
            CMD_CREATE: begin
                if (hit < 0) begin
                    r.status = STATUS_MISSING;
                end else if (!c.fok) begin
                    r.status = STATUS_NOIFACE;
                    r.slot = hit[SlotFieldW-1:0];
                    r.refs = tbl_refs[hit];
                end else begin
                    // The count sticks at its maximum.
                    if (tbl_refs[hit] != {RefsW{1'b1}})
                        tbl_refs[hit] = tbl_refs[hit] + 1'b1;
                    r.slot = hit[SlotFieldW-1:0];
                    r.refs = tbl_refs[hit];
                    r.agg = c.outer && tbl_flags[hit][AggFlagBit];
                end
                awaited_results.push_back(r);
            end
            default: begin
                limit = (c.maxc < MaxResults) ? int'(c.maxc) : MaxResults;
                n = 0;
                for (int i = 0; i < TableSlots; i++) begin
                    if (n < limit && tbl_valid[i]) begin
                        r = '0;
                        r.slot = i[SlotFieldW-1:0];
                        r.refs = tbl_refs[i];
                        r.khi = tbl_key_hi[i];
                        r.klo = tbl_key_lo[i];
                        r.cnt = CountW'(n + 1);
                        r.present = 1'b1;
                        awaited_results.push_back(r);
                        n++;
                    end
                end
                // An empty listing still answers with one closing transfer.
                if (n == 0)
                    awaited_results.push_back(r);
                else
                    awaited_results[awaited_results.size() - 1].last = 1'b1;
            end
        endcase
    endfunction

    function automatic void add_row(cmd_t cmd, logic [KeyW-1:0] khi, logic [KeyW-1:0] klo,
                                    logic [FlagsW-1:0] flags, logic outer, logic fok,
                                    logic [CountW-1:0] maxc, logic typed, status_t ts,
                                    logic [SlotFieldW-1:0] tslot, logic [RefsW-1:0] trefs);
        command_row_t row;
        row = '{cmd, khi, klo, flags, outer, fok, maxc, typed, ts, tslot, trefs};
        directed_rows.push_back(row);
    endfunction

    function automatic command_row_t random_row(cmd_t cmd, logic [KeyW-1:0] khi,
                                                logic [KeyW-1:0] klo);
        command_row_t row;
        row = '0;
        row.cmd = cmd;
        row.khi = khi;
        row.klo = klo;
        row.flags = FlagsW'($urandom);
        row.outer = 1'($urandom);
        row.fok = ($urandom_range(0, 99) < 80);
        row.maxc = CountW'($urandom_range(0, 63));
        return row;
    endfunction

    // Presents one command, waits for its transfer and records what it should cause.
    task automatic issue_command(command_row_t c);
        table_result_t t;
        if (idle_enabled && $urandom_range(0, 99) < 34) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd <= c.cmd;
        s_key_hi <= c.khi;
        s_key_lo <= c.klo;
        s_context_flags <= c.flags;
        s_outer_present <= c.outer;
        s_factory_ok <= c.fok;
        s_max_count <= c.maxc;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        commands_sent++;
        apply_table_command(c);
        // Hand-written rows replace the single computed result.
        if (c.typed) begin
            t = '0;
            t.status = c.t_status;
            t.slot = c.t_slot;
            t.refs = c.t_refs;
            t.last = 1'b1;
            void'(awaited_results.pop_back());
            awaited_results.push_back(t);
        end
    endtask

    // Holds the command side idle until every outstanding result has arrived.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (awaited_results.size() != 0);
    endtask

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endfunction

    // Result checker: each transfer is matched with the oldest expectation.
    always @(posedge aclk) begin
        table_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                $error("result transfer with nothing expected (slot %0d)", m_slot);
                error_count++;
            end else begin
                want = awaited_results.pop_front();
                compare_field("status", want.status, m_status);
                compare_field("slot", want.slot, m_slot);
                compare_field("ref_count", want.refs, m_ref_count);
                compare_field("aggregate_selected", want.agg, m_aggregate_selected);
                compare_field("entry_key_hi", want.khi, m_entry_key_hi);
                compare_field("entry_key_lo", want.klo, m_entry_key_lo);
                compare_field("item_count", want.cnt, m_item_count);
                compare_field("entry_present", want.present, m_entry_present);
                compare_field("last", want.last, m_last);
                results_checked++;
            end
        end
    end

    initial begin
        logic [KeyW-1:0] ka;
        logic [KeyW-1:0] kc_hi;
        logic [KeyW-1:0] kc_lo;
        command_row_t row;
        cmd_t c;
        int pick;
        int first_valid;
        int directed_count;

        ka = '1;
        kc_hi = 64'hA5A5_0F0F_3C3C_9669;
        kc_lo = 64'h5A5A_F0F0_C3C3_6996;
        for (int i = 0; i < TableSlots; i++)
            clear_table_slot(i);
        pool_hi[0] = ka;
        pool_lo[0] = ka;
        pool_hi[1] = '0;
        pool_lo[1] = '0;
        for (int i = 2; i < 6; i++) begin
            pool_hi[i] = {$urandom, $urandom};
            pool_lo[i] = {$urandom, $urandom};
        end

        // Directed commands: empty table, error codes, duplicates, aggregation, listings.
        add_row(CMD_ENUMERATE, '0, '0, 8'h00, 0, 0, 6'd63, 1, STATUS_OK, 0, 0);
        add_row(CMD_REVOKE, ka, ka, 8'h00, 0, 0, 6'd0, 1, STATUS_NOTREG, 0, 0);
        add_row(CMD_CREATE, ka, ka, 8'h00, 1, 1, 6'd0, 1, STATUS_MISSING, 0, 0);
        add_row(CMD_REGISTER, ka, ka, 8'hFF, 0, 0, 6'd0, 1, STATUS_OK, 0, 1);
        add_row(CMD_REGISTER, '0, '0, 8'h00, 0, 0, 6'd0, 1, STATUS_OK, 1, 1);
        add_row(CMD_REGISTER, kc_hi, kc_lo, 8'h10, 0, 0, 6'd0, 1, STATUS_OK, 2, 1);
        add_row(CMD_REGISTER, ka, ka, 8'h00, 0, 0, 6'd0, 1, STATUS_OK, 3, 1);
        add_row(CMD_CREATE, ka, ka, 8'h00, 1, 1, 6'd0, 0, STATUS_OK, 0, 0);
        add_row(CMD_CREATE, '0, '0, 8'hFF, 1, 1, 6'd63, 0, STATUS_OK, 0, 0);
        add_row(CMD_CREATE, kc_hi, kc_lo, 8'h00, 0, 1, 6'd0, 0, STATUS_OK, 0, 0);
        add_row(CMD_CREATE, kc_hi, kc_lo, 8'h00, 1, 0, 6'd0, 0, STATUS_OK, 0, 0);
        add_row(CMD_CREATE, kc_hi, kc_lo, 8'h00, 1, 1, 6'd0, 0, STATUS_OK, 0, 0);
        add_row(CMD_ENUMERATE, '0, '0, 8'h00, 0, 0, 6'd0, 1, STATUS_OK, 0, 0);
        add_row(CMD_ENUMERATE, ka, ka, 8'hFF, 1, 1, 6'd1, 0, STATUS_OK, 0, 0);
        add_row(CMD_ENUMERATE, '0, '0, 8'h00, 0, 0, 6'd32, 0, STATUS_OK, 0, 0);
        add_row(CMD_REVOKE, '0, '0, 8'h00, 0, 0, 6'd0, 0, STATUS_OK, 0, 0);
        add_row(CMD_REVOKE, '0, '0, 8'h00, 0, 0, 6'd0, 0, STATUS_OK, 0, 0);
        add_row(CMD_REVOKE, '0, '0, 8'h00, 0, 0, 6'd0, 1, STATUS_NOTREG, 0, 0);
        add_row(CMD_REGISTER, '0, '0, 8'hEF, 1, 1, 6'd63, 1, STATUS_OK, 1, 1);
        add_row(CMD_REVOKE, ka, ka, 8'h00, 0, 0, 6'd0, 0, STATUS_OK, 0, 0);
        add_row(CMD_ENUMERATE, '0, '0, 8'h00, 0, 0, 6'd63, 0, STATUS_OK, 0, 0);

        aresetn <= 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            issue_command(directed_rows[i]);
        directed_count = directed_rows.size();
        wait_drained();

        // Fill the table past its capacity, then list it in full.
        for (int i = 0; i < TableSlots; i++)
            issue_command(random_row(CMD_REGISTER, {$urandom, $urandom}, {$urandom, $urandom}));
        row = random_row(CMD_ENUMERATE, '0, '0);
        row.maxc = 6'd63;
        issue_command(row);
        wait_drained();

        // Empty the table by revoking the lowest live entry, with no idling on either side.
        idle_enabled = 1'b0;
        first_valid = 0;
        while (first_valid >= 0) begin
            first_valid = -1;
            for (int i = TableSlots - 1; i >= 0; i--)
                if (tbl_valid[i])
                    first_valid = i;
            if (first_valid >= 0)
                issue_command(random_row(CMD_REVOKE, tbl_key_hi[first_valid],
                                         tbl_key_lo[first_valid]));
        end
        wait_drained();
        idle_enabled = 1'b1;

        // Random traffic over a small key pool, with some unknown keys mixed in.
        for (int k = 0; k < 20; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 30)
                c = CMD_REGISTER;
            else if (pick < 55)
                c = CMD_REVOKE;
            else if (pick < 85)
                c = CMD_CREATE;
            else
                c = CMD_ENUMERATE;
            if ($urandom_range(0, 99) < 75) begin
                pick = $urandom_range(0, 5);
                row = random_row(c, pool_hi[pick], pool_lo[pick]);
            end else begin
                row = random_row(c, {$urandom, $urandom}, {$urandom, $urandom});
            end
            issue_command(row);
            if ($urandom_range(0, 99) < 4)
                wait_drained();
        end

        wait_drained();
        repeat (SettleCycles) @(posedge aclk);
        $display("Run covered %0d commands (%0d directed, plus fill, drain and random traffic)",
                 commands_sent, directed_count);
        $display("and checked %0d result transfers field by field.", results_checked);
        if (error_count == 0)
            $display("tb_refcounted_key_registration_table_unit: clean");
        else
            $display("tb_refcounted_key_registration_table_unit: errors");
        $finish;
    end

endmodule
